// ----- sv/aiir_pkg.sv -----
package aiir_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_STAGE_ENABLE = 3'd0,
        REG_HP_COEFFS    = 3'd1,
        REG_LP_NUM_LOW   = 3'd2,
        REG_LP_NUM_HIGH  = 3'd3,
        REG_LP_DEN_LOW   = 3'd4,
        REG_LP_DEN_HIGH  = 3'd5
    } cfg_idx_t;

    localparam int CFG_DATA_W = 48;

    // Coefficient selector for the shared multiplier
    typedef enum logic [3:0] {
        C_HP_G   = 4'd0,
        C_HP_FB1 = 4'd1,
        C_HP_FB2 = 4'd2,
        C_LP_A0  = 4'd3,
        C_LP_A1  = 4'd4,
        C_LP_A2  = 4'd5,
        C_LP_A3  = 4'd6,
        C_LP_A4  = 4'd7,
        C_LP_A5  = 4'd8,
        C_LP_B1  = 4'd9,
        C_LP_B2  = 4'd10,
        C_LP_B3  = 4'd11,
        C_LP_B4  = 4'd12,
        C_LP_B5  = 4'd13
    } coef_sel_t;

    typedef enum logic {
        SRC_X = 1'b0,
        SRC_Y = 1'b1
    } mul_src_t;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_HP_T    = 3'd1,  // t = m, y = m + hp_d0
        OP_HP_D0   = 3'd2,  // hp_d0 = -2t - m + hp_d1
        OP_HP_OUT  = 3'd3,  // hp_d1 = t - m, x = sat(1.5 y)
        OP_LP_Y    = 3'd4,  // y = m + lp ring head
        OP_ACC     = 3'd5,  // acc = m
        OP_LP_D    = 3'd6,  // push acc - m + lp ring tap 1, rotate
        OP_LP_LAST = 3'd7   // push acc - m, rotate, x = sat(y)
    } alu_op_t;

    typedef enum logic [1:0] {
        JMP_NONE  = 2'd0,
        JMP_NO_HP = 2'd1,
        JMP_NO_LP = 2'd2,
        JMP_END   = 2'd3   // hold here until the output register is free
    } jmp_t;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_ENTRY   = 5'd0;
    localparam step_t STEP_LP_TEST = 5'd6;
    localparam step_t STEP_END     = 5'd19;

    typedef struct packed {
        logic      mul_en;
        mul_src_t  mul_src;
        coef_sel_t coef;
        logic      shift13;
        alu_op_t   op;
        jmp_t      jmp;
        step_t     target;
    } ucode_t;

    function automatic ucode_t uc(logic mul_en, mul_src_t src, coef_sel_t coef,
                                  logic shift13, alu_op_t op, jmp_t jmp, step_t target);
        ucode_t w;
        w.mul_en  = mul_en;
        w.mul_src = src;
        w.coef    = coef;
        w.shift13 = shift13;
        w.op      = op;
        w.jmp     = jmp;
        w.target  = target;
        return w;
    endfunction

    // Microprogram: high-pass block, then low-pass block, then output
    function automatic ucode_t ucode_rom(step_t pc);
        ucode_t w;
        case (pc)
            5'd0:  w = uc(1'b0, SRC_X, C_HP_G,   1'b0, OP_NONE,    JMP_NO_HP, STEP_LP_TEST);
            5'd1:  w = uc(1'b1, SRC_X, C_HP_G,   1'b0, OP_NONE,    JMP_NONE,  STEP_ENTRY);
            5'd2:  w = uc(1'b0, SRC_X, C_HP_G,   1'b0, OP_HP_T,    JMP_NONE,  STEP_ENTRY);
            5'd3:  w = uc(1'b1, SRC_Y, C_HP_FB1, 1'b0, OP_NONE,    JMP_NONE,  STEP_ENTRY);
            5'd4:  w = uc(1'b1, SRC_Y, C_HP_FB2, 1'b0, OP_HP_D0,   JMP_NONE,  STEP_ENTRY);
            5'd5:  w = uc(1'b0, SRC_X, C_HP_G,   1'b0, OP_HP_OUT,  JMP_NONE,  STEP_ENTRY);
            5'd6:  w = uc(1'b0, SRC_X, C_HP_G,   1'b0, OP_NONE,    JMP_NO_LP, STEP_END);
            5'd7:  w = uc(1'b1, SRC_X, C_LP_A0,  1'b1, OP_NONE,    JMP_NONE,  STEP_ENTRY);
            5'd8:  w = uc(1'b1, SRC_X, C_LP_A1,  1'b1, OP_LP_Y,    JMP_NONE,  STEP_ENTRY);
            5'd9:  w = uc(1'b1, SRC_Y, C_LP_B1,  1'b1, OP_ACC,     JMP_NONE,  STEP_ENTRY);
            5'd10: w = uc(1'b1, SRC_X, C_LP_A2,  1'b1, OP_LP_D,    JMP_NONE,  STEP_ENTRY);
            5'd11: w = uc(1'b1, SRC_Y, C_LP_B2,  1'b1, OP_ACC,     JMP_NONE,  STEP_ENTRY);
            5'd12: w = uc(1'b1, SRC_X, C_LP_A3,  1'b1, OP_LP_D,    JMP_NONE,  STEP_ENTRY);
            5'd13: w = uc(1'b1, SRC_Y, C_LP_B3,  1'b1, OP_ACC,     JMP_NONE,  STEP_ENTRY);
            5'd14: w = uc(1'b1, SRC_X, C_LP_A4,  1'b1, OP_LP_D,    JMP_NONE,  STEP_ENTRY);
            5'd15: w = uc(1'b1, SRC_Y, C_LP_B4,  1'b1, OP_ACC,     JMP_NONE,  STEP_ENTRY);
            5'd16: w = uc(1'b1, SRC_X, C_LP_A5,  1'b1, OP_LP_D,    JMP_NONE,  STEP_ENTRY);
            5'd17: w = uc(1'b1, SRC_Y, C_LP_B5,  1'b1, OP_ACC,     JMP_NONE,  STEP_ENTRY);
            5'd18: w = uc(1'b0, SRC_X, C_HP_G,   1'b1, OP_LP_LAST, JMP_NONE,  STEP_ENTRY);
            default: w = uc(1'b0, SRC_X, C_HP_G, 1'b0, OP_NONE,    JMP_END,   STEP_END);
        endcase
        return w;
    endfunction

    // Clamp a 32-bit two's complement value to signed 16 bits
    function automatic logic signed [15:0] sat16(logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/audio_iir_hp_lp_cascade_unit.sv -----
// Two cascaded fixed-point IIR stages (transposed direct form II) on a stream
// of signed 16-bit audio samples: an optional second-order high-pass (Q12 gain
// and feedback, numerator 1,-2,1, 1.5x boost) followed by an optional
// fifth-order low-pass (six Q13 numerator and five Q13 feedback taps). Each
// enabled stage saturates to 16 bits; everything inside wraps at 32 bits.
// tlast passes through untouched. One sample is in flight at a time: a small
// microprogram drives a single 32x16 multiplier, one product per step. From
// the transfer of a sample, the program steps only through the enabled stages
// until the result lands in the output register; the next sample is taken in
// the cycle after that. The multiplier and its product register set the
// pace: every tap costs one step on it. The result waits in the output
// register while the next sample is already being worked on; the program
// holds on its last step if that register is still full. Configuration
// writes belong to idle time only.
module audio_iir_hp_lp_cascade_unit
    import aiir_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] pcm_in
    input  logic                  s_tlast,   // frame_last_in
    // filtered samples
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] pcm_out
    output logic                  m_tlast    // frame_last_out
);

    // configuration registers
    logic [1:0]  stage_en_reg;
    logic [47:0] hp_coeffs_reg;
    logic [47:0] lp_num_low_reg;
    logic [47:0] lp_num_high_reg;
    logic [47:0] lp_den_low_reg;
    logic [31:0] lp_den_high_reg;

    // sequencer
    logic  busy_reg;
    step_t pc_reg;
    step_t pc_next;
    ucode_t ucw;

    // datapath
    logic signed [15:0] x_reg;
    logic               last_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] m_reg;
    logic signed [31:0] hp_d_reg [0:1];
    logic signed [31:0] lp_d_reg [0:4];

    // output register
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic in_xfer;
    logic out_free;
    logic at_end;
    logic load_out;

    logic signed [15:0] coef_val;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_full;
    logic signed [31:0] mul_low;
    logic signed [31:0] mul_sh;
    logic signed [31:0] boost;
    logic signed [31:0] lp_push;

    assign s_tready = !busy_reg;
    assign in_xfer  = s_tvalid && !busy_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ucw      = ucode_rom(pc_reg);
    assign at_end   = busy_reg && (ucw.jmp == JMP_END);
    assign load_out = at_end && out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // coefficient select
    always_comb begin
        case (ucw.coef)
            C_HP_G:   coef_val = hp_coeffs_reg[15:0];
            C_HP_FB1: coef_val = hp_coeffs_reg[31:16];
            C_HP_FB2: coef_val = hp_coeffs_reg[47:32];
            C_LP_A0:  coef_val = lp_num_low_reg[15:0];
            C_LP_A1:  coef_val = lp_num_low_reg[31:16];
            C_LP_A2:  coef_val = lp_num_low_reg[47:32];
            C_LP_A3:  coef_val = lp_num_high_reg[15:0];
            C_LP_A4:  coef_val = lp_num_high_reg[31:16];
            C_LP_A5:  coef_val = lp_num_high_reg[47:32];
            C_LP_B1:  coef_val = lp_den_low_reg[15:0];
            C_LP_B2:  coef_val = lp_den_low_reg[31:16];
            C_LP_B3:  coef_val = lp_den_low_reg[47:32];
            C_LP_B4:  coef_val = lp_den_high_reg[15:0];
            C_LP_B5:  coef_val = lp_den_high_reg[31:16];
            default:  coef_val = '0;
        endcase
    end

    // shared multiplier: keep the low 32 bits, then arithmetic shift
    assign mul_a    = (ucw.mul_src == SRC_Y) ? y_reg : {{16{x_reg[15]}}, x_reg};
    assign mul_full = mul_a * coef_val;
    assign mul_low  = $signed(mul_full[31:0]);
    assign mul_sh   = ucw.shift13 ? (mul_low >>> 13) : (mul_low >>> 12);

    assign boost   = y_reg + (y_reg >>> 1);
    assign lp_push = (ucw.op == OP_LP_LAST) ? (acc_reg - m_reg)
                                             : (acc_reg - m_reg + lp_d_reg[1]);

    // next step: conditional jumps skip disabled stages, hold at the end until the output register is free
    always_comb begin
        pc_next = pc_reg + 5'd1;
        case (ucw.jmp)
            JMP_NO_HP: if (!stage_en_reg[0]) pc_next = ucw.target;
            JMP_NO_LP: if (!stage_en_reg[1]) pc_next = ucw.target;
            JMP_END:   pc_next = out_free ? STEP_ENTRY : pc_reg;
            default:   pc_next = pc_reg + 5'd1;
        endcase
    end

    // configuration; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_en_reg    <= '0;
            hp_coeffs_reg   <= '0;
            lp_num_low_reg  <= '0;
            lp_num_high_reg <= '0;
            lp_den_low_reg  <= '0;
            lp_den_high_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_STAGE_ENABLE: stage_en_reg    <= cfg_wdata[1:0];
                REG_HP_COEFFS:    hp_coeffs_reg   <= cfg_wdata[47:0];
                REG_LP_NUM_LOW:   lp_num_low_reg  <= cfg_wdata[47:0];
                REG_LP_NUM_HIGH:  lp_num_high_reg <= cfg_wdata[47:0];
                REG_LP_DEN_LOW:   lp_den_low_reg  <= cfg_wdata[47:0];
                REG_LP_DEN_HIGH:  lp_den_high_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= STEP_ENTRY;
        end else if (!busy_reg) begin
            if (in_xfer) begin
                busy_reg <= 1'b1;
                pc_reg   <= STEP_ENTRY;
            end
        end else begin
            pc_reg <= pc_next;
            if (load_out) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // payload registers of the datapath
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            x_reg    <= $signed(s_tdata);
            last_reg <= s_tlast;
        end
        if (busy_reg) begin
            if (ucw.mul_en) begin
                m_reg <= mul_sh;
            end
            case (ucw.op)
                OP_HP_T: begin
                    t_reg <= m_reg;
                    y_reg <= m_reg + hp_d_reg[0];
                end
                OP_HP_OUT: x_reg <= sat16(boost);
                OP_LP_Y:   y_reg <= m_reg + lp_d_reg[0];
                OP_ACC:    acc_reg <= m_reg;
                OP_LP_LAST: x_reg <= sat16(y_reg);
                default: ;
            endcase
        end
    end

    // filter state: high-pass pair and low-pass ring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_d_reg[0] <= '0;
            hp_d_reg[1] <= '0;
            for (int j = 0; j < 5; j++) begin
                lp_d_reg[j] <= '0;
            end
        end else if (busy_reg) begin
            case (ucw.op)
                OP_HP_D0:  hp_d_reg[0] <= (32'sd0 - (t_reg <<< 1)) - m_reg + hp_d_reg[1];
                OP_HP_OUT: hp_d_reg[1] <= t_reg - m_reg;
                OP_LP_D, OP_LP_LAST: begin
                    // advance the ring: tap 1 always holds the next old value
                    for (int j = 0; j < 4; j++) begin
                        lp_d_reg[j] <= lp_d_reg[j+1];
                    end
                    lp_d_reg[4] <= lp_push;
                end
                default: ;
            endcase
        end
    end

    // output register: load at the last step, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= x_reg;
            m_tlast_reg <= last_reg;
        end
    end

    // checks
    a_idle_at_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> pc_reg == STEP_ENTRY)
        else $error("sequencer idle away from entry step");

    a_pc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pc_reg <= STEP_END)
        else $error("step counter ran past the program");

    a_end_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid_reg && !busy_reg)
        else $error("finished sample not presented");

    a_start_on_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> busy_reg && pc_reg == STEP_ENTRY)
        else $error("sample transfer did not start the program");

endmodule
